>>> design/bfa_pkg.sv
// Types and constants shared by the best-fit allocator modules.
package bfa_pkg;

	localparam int unsigned SizeW = 20;
	localparam int unsigned EndW  = 21;
	localparam int unsigned IdW   = 16;
	localparam int unsigned TimeW = 24;
	localparam int unsigned CntW  = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOAD,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t              operation;
		logic [IdW-1:0]   process_id;
		logic [SizeW-1:0] process_size;
		logic [TimeW-1:0] process_duration;
		logic [TimeW-1:0] tick_amount;
	} cmd_t;

	typedef struct packed {
		logic             accepted;
		logic [SizeW-1:0] placed_at;
		logic [SizeW-1:0] free_memory;
		logic [CntW-1:0]  freed_count;
	} result_t;

	// Control and broadcast data from the sequencer to every cell.
	typedef struct packed {
		logic             clear;
		logic             load_tok;
		logic             scan;
		logic             load_res;
		logic             shift_res;
		logic             kill;
		logic             is_tick;
		logic [IdW-1:0]   id;
		logic [TimeW-1:0] amt;
		logic [SizeW-1:0] need;
		logic [TimeW-1:0] dur;
		logic [SizeW-1:0] wr_start;
		logic [SizeW-1:0] mem_size;
	} ctl_t;

	// Word handed from one cell to the next.
	typedef struct packed {
		logic             tok_v;
		logic [SizeW-1:0] tok_s;
		logic             found;
		logic [EndW-1:0]  at;
		logic [EndW-1:0]  gap;
		logic             rel;
		logic [SizeW-1:0] len;
	} link_t;

endpackage

>>> design/bfa_cell.sv
// One table slot of the allocator chain.
module bfa_cell
	import bfa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  ctl_t  ctl,
	input  logic  wr,
	input  link_t prev,
	output link_t link,
	output logic  valid
);

	logic             valid_q;
	logic [SizeW-1:0] start_q;
	logic [SizeW-1:0] len_q;
	logic [IdW-1:0]   owner_q;
	logic [TimeW-1:0] time_q;
	logic [EndW-1:0]  nxt_q;
	link_t            link_q;
	logic [EndW-1:0]  end_addr;
	logic [EndW-1:0]  gap;
	logic             rel;
	logic             fits;

	assign end_addr = {1'b0, start_q} + {1'b0, len_q};
	assign gap      = nxt_q - end_addr;
	assign fits     = valid_q && (nxt_q >= end_addr) && (gap >= {1'b0, ctl.need})
		&& (ctl.need != '0);
	assign rel      = valid_q && (ctl.is_tick ? (time_q <= ctl.amt) : (owner_q == ctl.id));
	assign link     = link_q;
	assign valid    = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (wr) begin
			valid_q <= 1'b1;
		end else if (ctl.kill && rel) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			start_q <= ctl.wr_start;
			len_q   <= ctl.need;
			owner_q <= ctl.id;
			time_q  <= ctl.dur;
		end else if (ctl.kill && ctl.is_tick && valid_q && !rel) begin
			time_q <= time_q - ctl.amt;
		end

		if (ctl.load_tok) begin
			link_q.tok_v <= valid_q;
			link_q.tok_s <= start_q;
			nxt_q        <= {1'b0, ctl.mem_size};
		end else if (ctl.scan) begin
			if (link_q.tok_v && ({1'b0, link_q.tok_s} >= end_addr)
				&& ({1'b0, link_q.tok_s} < nxt_q)) begin
				nxt_q <= {1'b0, link_q.tok_s};
			end
			link_q.tok_v <= prev.tok_v;
			link_q.tok_s <= prev.tok_s;
		end

		if (ctl.kill) begin
			link_q.found <= 1'b0;
			link_q.rel   <= rel;
			link_q.len   <= len_q;
		end else if (ctl.load_res) begin
			link_q.found <= fits;
			link_q.at    <= end_addr;
			link_q.gap   <= gap;
			link_q.rel   <= 1'b0;
		end else if (ctl.shift_res) begin
			link_q.found <= prev.found;
			link_q.at    <= prev.at;
			link_q.gap   <= prev.gap;
			link_q.rel   <= prev.rel;
			link_q.len   <= prev.len;
		end
	end

endmodule

>>> design/best_fit_process_memory_allocator_unit.sv
// Top level of the best-fit process memory allocator.
//
// Usage: drive cmd and raise start while busy is low; the command word is
// taken at that edge and busy stays high until the result is ready. The
// result word appears on result with done high for exactly one cycle; the
// receiver cannot stall it. A new command may start in the cycle done is high.
// Insert and query first rotate slot starts around the cell ring so each
// cell finds the next start at or above its end, then latch candidates,
// then shift candidates out of the chain into the best-fit compare.
// Remove and tick shift freed lengths out of the chain one slot per cycle
// into the free-memory adder.
// The memory size register is written through cfg_valid/cfg_ready/cfg_data,
// taken only while idle; a write empties the table and sets free memory.
// Reset empties the table and clears memory size and free memory to zero.
module best_fit_process_memory_allocator_unit
	import bfa_pkg::*;
#(
	parameter int unsigned MAX_PROCS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             done,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [SizeW-1:0] cfg_data
);

	localparam int unsigned CW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

	state_t           state_q, state_d;
	logic [CW-1:0]    cnt_q;
	cmd_t             cmd_q, cur;
	logic [SizeW-1:0] mem_size_q;
	logic [SizeW-1:0] unalloc_q;
	logic [EndW-1:0]  z_nxt_q;
	logic             best_found_q;
	logic [EndW-1:0]  best_at_q;
	logic [EndW-1:0]  best_gap_q;
	logic [CntW-1:0]  freed_q;
	logic             done_q;
	result_t          result_q;
	ctl_t             ctl;
	link_t            links [MAX_PROCS];
	link_t            prevs [MAX_PROCS];
	logic [MAX_PROCS-1:0] valids;
	logic [MAX_PROCS-1:0] wr;
	logic             has_free;
	logic [CW-1:0]    free_idx;
	logic             gap_op, accept, cfg_wr, ins_ok, last;
	link_t            tail;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign done      = done_q;
	assign result    = result_q;
	assign cur       = (state_q == ST_IDLE) ? cmd : cmd_q;
	assign gap_op    = (cmd.operation == OP_INSERT) || (cmd.operation == OP_QUERY);
	assign last      = (cnt_q == CW'(MAX_PROCS - 1));
	assign tail      = links[MAX_PROCS-1];
	assign ins_ok    = (cmd_q.operation == OP_INSERT) && best_found_q && has_free;

	always_comb begin
		has_free = 1'b0;
		free_idx = '0;
		for (int i = MAX_PROCS - 1; i >= 0; i--) begin
			if (!valids[i]) begin
				has_free = 1'b1;
				free_idx = CW'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = gap_op ? ST_SCAN : ST_DRAIN;
				end
			end
			ST_SCAN:  if (last) state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_DRAIN;
			ST_DRAIN: if (last) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.clear     = cfg_wr;
		ctl.load_tok  = accept && gap_op;
		ctl.kill      = accept && !gap_op;
		ctl.scan      = (state_q == ST_SCAN);
		ctl.load_res  = (state_q == ST_LOAD);
		ctl.shift_res = (state_q == ST_DRAIN);
		ctl.is_tick   = (cur.operation == OP_TICK);
		ctl.id        = cur.process_id;
		ctl.amt       = cur.tick_amount;
		ctl.need      = cur.process_size;
		ctl.dur       = cur.process_duration;
		ctl.wr_start  = best_at_q[SizeW-1:0];
		ctl.mem_size  = mem_size_q;
		wr            = '0;
		if (state_q == ST_DONE && ins_ok) begin
			wr[free_idx] = 1'b1;
		end
	end

	for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
		always_comb begin
			prevs[g]       = '0;
			prevs[g].tok_v = links[(g + MAX_PROCS - 1) % MAX_PROCS].tok_v;
			prevs[g].tok_s = links[(g + MAX_PROCS - 1) % MAX_PROCS].tok_s;
			if (g > 0) begin
				prevs[g] = links[(g + MAX_PROCS - 1) % MAX_PROCS];
			end
		end

		bfa_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.wr    (wr[g]),
			.prev  (prevs[g]),
			.link  (links[g]),
			.valid (valids[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			mem_size_q <= '0;
			unalloc_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_DONE);
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else if (state_q == ST_SCAN || state_q == ST_DRAIN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cfg_wr) begin
				mem_size_q <= cfg_data;
				unalloc_q  <= cfg_data;
			end else if (state_q == ST_DRAIN && tail.rel) begin
				unalloc_q <= unalloc_q + tail.len;
			end else if (state_q == ST_DONE && ins_ok) begin
				unalloc_q <= unalloc_q - cmd_q.process_size;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			freed_q <= '0;
			z_nxt_q <= {1'b0, mem_size_q};
		end
		if (state_q == ST_SCAN && links[0].tok_v && ({1'b0, links[0].tok_s} < z_nxt_q)) begin
			z_nxt_q <= {1'b0, links[0].tok_s};
		end
		if (state_q == ST_LOAD) begin
			best_found_q <= (cmd_q.process_size != '0) && (z_nxt_q >= {1'b0, cmd_q.process_size});
			best_at_q    <= '0;
			best_gap_q   <= z_nxt_q;
		end
		if (state_q == ST_DRAIN) begin
			if (tail.rel) begin
				freed_q <= freed_q + 1'b1;
			end
			if (tail.found && (!best_found_q || tail.gap < best_gap_q
				|| (tail.gap == best_gap_q && tail.at < best_at_q))) begin
				best_found_q <= 1'b1;
				best_at_q    <= tail.at;
				best_gap_q   <= tail.gap;
			end
		end
		if (state_q == ST_DONE) begin
			result_q.accepted    <= 1'b0;
			result_q.placed_at   <= '0;
			result_q.freed_count <= freed_q;
			result_q.free_memory <= ins_ok ? (unalloc_q - cmd_q.process_size) : unalloc_q;
			if (cmd_q.operation == OP_QUERY) begin
				result_q.accepted    <= best_found_q;
				result_q.freed_count <= '0;
			end else if (cmd_q.operation == OP_INSERT) begin
				result_q.accepted    <= ins_ok;
				result_q.placed_at   <= ins_ok ? best_at_q[SizeW-1:0] : '0;
				result_q.freed_count <= '0;
			end
		end
	end

endmodule

>>> design/bfa_checker.sv
// Port-level checks for the best-fit allocator, bound to the top level.
module bfa_checker
	import bfa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done) else $error("done right after accept");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready) else $error("config ready while busy");

endmodule

bind best_fit_process_memory_allocator_unit bfa_checker u_bfa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.cfg_ready(cfg_ready)
);

>>> tb/testbench.sv
// Self-checking testbench for the best-fit process memory allocator unit.
`timescale 1ns / 1ps

module testbench;
	import bfa_pkg::*;

	localparam int Slots = 16;
	localparam int Settle = 2 * Slots + 8;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	cmd_t             cmd = '0;
	logic             done;
	result_t          result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [SizeW-1:0] cfg_data = '0;

	best_fit_process_memory_allocator_unit #(.MAX_PROCS(Slots)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Allocator shadow state
	logic             used [Slots];
	logic [SizeW-1:0] base [Slots];
	logic [SizeW-1:0] span [Slots];
	logic [IdW-1:0]   owner [Slots];
	logic [TimeW-1:0] left [Slots];
	logic [SizeW-1:0] mem_total = '0;
	logic [SizeW-1:0] free_units = '0;

	result_t pending_results[$];
	int      errors = 0;
	bit      gaps_on = 1'b1;

	task automatic mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	function automatic void empty_table();
		for (int i = 0; i < Slots; i++) used[i] = 1'b0;
		free_units = mem_total;
	endfunction

	function automatic longint next_base(input longint pos);
		longint best;
		best = mem_total;
		for (int i = 0; i < Slots; i++)
			if (used[i] && base[i] >= pos && base[i] < best) best = base[i];
		return best;
	endfunction

	function automatic bit best_gap(input longint need, output longint where);
		bit     found;
		longint at, nxt, gap, best_len;
		found = 1'b0;
		where = 0;
		best_len = 0;
		if (need == 0) return 1'b0;
		for (int i = -1; i < Slots; i++) begin
			if (i >= 0 && !used[i]) continue;
			at = (i < 0) ? 0 : longint'(base[i]) + longint'(span[i]);
			nxt = next_base(at);
			if (nxt < at) continue;
			gap = nxt - at;
			if (gap < need) continue;
			if (!found || gap < best_len || (gap == best_len && at < where)) begin
				found = 1'b1;
				where = at;
				best_len = gap;
			end
		end
		return found;
	endfunction

	function automatic result_t predict_result(input cmd_t c);
		result_t r;
		int      slot;
		longint  where;
		r = '0;
		case (c.operation)
			OP_INSERT: begin
				slot = -1;
				for (int i = Slots - 1; i >= 0; i--) if (!used[i]) slot = i;
				if (slot >= 0 && best_gap(c.process_size, where)) begin
					used[slot] = 1'b1;
					base[slot] = where[SizeW-1:0];
					span[slot] = c.process_size;
					owner[slot] = c.process_id;
					left[slot] = c.process_duration;
					free_units = free_units - c.process_size;
					r.accepted = 1'b1;
					r.placed_at = where[SizeW-1:0];
				end
			end
			OP_REMOVE: begin
				for (int i = 0; i < Slots; i++)
					if (used[i] && owner[i] == c.process_id) begin
						used[i] = 1'b0;
						free_units = free_units + span[i];
						r.freed_count++;
					end
			end
			OP_TICK: begin
				for (int i = 0; i < Slots; i++) begin
					if (!used[i]) continue;
					if (left[i] <= c.tick_amount) begin
						used[i] = 1'b0;
						free_units = free_units + span[i];
						r.freed_count++;
					end else begin
						left[i] = left[i] - c.tick_amount;
					end
				end
			end
			default: begin
				r.accepted = best_gap(c.process_size, where);
			end
		endcase
		r.free_memory = free_units;
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch("unexpected result, accepted", result.accepted, 0);
			end else begin
				want = pending_results.pop_front();
				if (result.accepted !== want.accepted)
					mismatch("accepted", result.accepted, want.accepted);
				if (result.placed_at !== want.placed_at)
					mismatch("placed_at", result.placed_at, want.placed_at);
				if (result.free_memory !== want.free_memory)
					mismatch("free_memory", result.free_memory, want.free_memory);
				if (result.freed_count !== want.freed_count)
					mismatch("freed_count", result.freed_count, want.freed_count);
			end
		end
	end

	// Called at a falling edge; returns at a falling edge.
	task automatic issue_cmd(input op_t op, input logic [IdW-1:0] id,
			input logic [SizeW-1:0] size, input logic [TimeW-1:0] dur,
			input logic [TimeW-1:0] amt);
		cmd_t c;
		c.operation = op;
		c.process_id = id;
		c.process_size = size;
		c.process_duration = dur;
		c.tick_amount = amt;
		cmd = c;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy) break;
			@(negedge clk);
		end
		pending_results.push_back(predict_result(c));
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
	endtask

	task automatic write_mem_size(input logic [SizeW-1:0] value);
		start = 1'b0;
		wait (pending_results.size() == 0);
		repeat (Settle) @(negedge clk);
		cfg_data = value;
		cfg_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
			@(negedge clk);
		end
		mem_total = value;
		empty_table();
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_unconfigured();
		issue_cmd(OP_INSERT, 16'h0001, 20'd1, 24'd5, 24'd0);
		issue_cmd(OP_QUERY, 16'h0000, 20'd1, 24'd0, 24'd0);
		write_mem_size(20'd0);
		issue_cmd(OP_TICK, 16'h0000, 20'd0, 24'd0, 24'd0);
	endtask

	task automatic test_directed();
		write_mem_size(20'd1000);
		issue_cmd(OP_INSERT, 16'h0000, 20'd0, 24'd9, 24'd0);
		issue_cmd(OP_QUERY, 16'hFFFF, 20'd0, 24'd0, 24'd0);
		issue_cmd(OP_INSERT, 16'h0007, 20'd100, 24'd0, 24'd0);
		issue_cmd(OP_INSERT, 16'hFFFF, 20'd200, 24'hFFFFFF, 24'd0);
		issue_cmd(OP_INSERT, 16'h0007, 20'd50, 24'd3, 24'd0);
		issue_cmd(OP_REMOVE, 16'h0007, 20'd0, 24'd0, 24'd0);
		issue_cmd(OP_INSERT, 16'h0002, 20'd40, 24'd2, 24'd0);
		issue_cmd(OP_QUERY, 16'h0000, 20'd1001, 24'd0, 24'd0);
		issue_cmd(OP_TICK, 16'h0000, 20'd0, 24'd0, 24'd0);
		issue_cmd(OP_TICK, 16'h0000, 20'd0, 24'd0, 24'd2);
		issue_cmd(OP_TICK, 16'h0000, 20'd0, 24'd0, 24'hFFFFFF);
		for (int i = 0; i < Slots + 1; i++)
			issue_cmd(OP_INSERT, 16'(i), 20'd10, 24'(i + 1), 24'd0);
		issue_cmd(OP_QUERY, 16'h0000, 20'd500, 24'd0, 24'd0);
		write_mem_size(20'hFFFFF);
		issue_cmd(OP_INSERT, 16'hA5A5, 20'hFFFFF, 24'h123456, 24'd0);
		issue_cmd(OP_QUERY, 16'h0000, 20'd1, 24'd0, 24'd0);
		issue_cmd(OP_REMOVE, 16'hA5A5, 20'd0, 24'd0, 24'd0);
	endtask

	task automatic test_random(input logic [SizeW-1:0] mem, input int count,
			input int max_size);
		op_t              op;
		logic [IdW-1:0]   id;
		logic [SizeW-1:0] size;
		logic [TimeW-1:0] dur, amt;
		write_mem_size(mem);
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: op = OP_INSERT;
				4, 5:       op = OP_REMOVE;
				6, 7:       op = OP_TICK;
				default:    op = OP_QUERY;
			endcase
			id = 16'($urandom_range(0, 7));
			size = 20'($urandom_range(1, max_size));
			dur = 24'($urandom_range(0, 40));
			amt = 24'($urandom_range(0, 12));
			if ($urandom_range(0, 15) == 0) begin
				id = 16'($urandom);
				size = 20'($urandom);
				dur = 24'($urandom);
				amt = 24'($urandom);
			end
			issue_cmd(op, id, size, dur, amt);
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_unconfigured();
		test_directed();
		test_random(20'd200, 110, 40);
		test_random(20'd37, 60, 12);
		test_random(20'hFFFFF, 100, 200000);
		gaps_on = 1'b0;
		test_random(20'd4096, 150, 600);
		start = 1'b0;
		wait (pending_results.size() == 0);
		repeat (Settle) @(negedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
design/bfa_pkg.sv
design/bfa_cell.sv
design/best_fit_process_memory_allocator_unit.sv
design/bfa_checker.sv
tb/testbench.sv
